// File: rtl/ophs_pkg.sv
// Shared types and constants for the one-hot plane shift and latch driver.
package ophs_pkg;

   // Sequencer phases, one-hot coded
   typedef enum logic [9:0] {
      PH_IDLE        = 10'b00_0000_0001,
      PH_SET_HI      = 10'b00_0000_0010,
      PH_WAIT_HI     = 10'b00_0000_0100,
      PH_SET_LO      = 10'b00_0000_1000,
      PH_WAIT_LO     = 10'b00_0001_0000,
      PH_WRITTEN     = 10'b00_0010_0000,
      PH_STO_SET_HI  = 10'b00_0100_0000,
      PH_STO_WAIT_HI = 10'b00_1000_0000,
      PH_STO_SET_LO  = 10'b01_0000_0000,
      PH_STO_WAIT_LO = 10'b10_0000_0000
   } phase_type;

   localparam int HOLD_W  = 8;
   localparam int PLANE_W = 4;
   // bit counter covers the largest supported shift length of 32
   localparam int BIT_W   = 5;

   localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd1;

   // Result of one hold timer tick
   typedef struct packed {
      logic              done;
      logic [HOLD_W-1:0] count;
   } hold_step_type;

endpackage

// File: rtl/onehot_plane_shift_latch_driver_core.sv
// Top level of the one-hot plane shift and latch driver.

// Each accepted request transaction is one timing tick of the pin waveforms and
// produces exactly one response transaction with the pin levels and status after
// that tick. A request is taken in every cycle in which the response register is
// empty or being drained, so the sustained rate is one transaction per clock when
// the response side does not stall; each response is held in the single response
// register behind the tick logic. A posted plane is shifted out as EDGE bits,
// each with a clock high and a clock low phase held for hold_ticks ticks (0 or
// 1 means one tick), data high only at the bit equal to the plane. After the last
// bit the block waits for a latch request and then pulses the store line with the
// same hold. soft_reset returns the sequencer to idle but leaves the pin levels.
// hold_ticks is written through the csr port and resets to 1; write it only
// while no request is in flight.
module onehot_plane_shift_latch_driver_core #(
   parameter int EDGE = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ophs_pkg::HOLD_W-1:0]   csr_hold_ticks,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_plane_valid,
   input  logic [ophs_pkg::PLANE_W-1:0]  req_plane_index,
   input  logic                          req_latch_request,
   input  logic                          req_soft_reset,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_data_out,
   output logic                          rsp_clock_out,
   output logic                          rsp_store_out,
   output logic                          rsp_ready_for_plane,
   output logic                          rsp_ready_to_latch
);

   localparam int BW = ophs_pkg::BIT_W;

   // state
   ophs_pkg::phase_type              phase_ff, phase_in;
   logic [ophs_pkg::HOLD_W-1:0]      hold_count_ff, hold_count_in;
   logic [BW-1:0]                    bit_count_ff, bit_count_in;
   logic [ophs_pkg::PLANE_W-1:0]     active_plane_ff, active_plane_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [ophs_pkg::PLANE_W-1:0]     pend_plane_ff, pend_plane_in;
   logic                             latch_pend_ff, latch_pend_in;
   logic                             data_ff, data_in;
   logic                             clk_pin_ff, clk_pin_in;
   logic                             store_ff, store_in;
   logic [ophs_pkg::HOLD_W-1:0]      hold_ticks_ff;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_rfp_ff, rsp_rtl_ff;

   logic                             req_accept;
   logic                             rsp_take;
   ophs_pkg::hold_step_type          hs;
   logic [BW:0]                      bit_next;

   // one tick of the hold timer
   function automatic ophs_pkg::hold_step_type hold_tick(
      input logic [ophs_pkg::HOLD_W-1:0] count,
      input logic [ophs_pkg::HOLD_W-1:0] limit
   );
      ophs_pkg::hold_step_type r;
      logic [ophs_pkg::HOLD_W-1:0] inc;
      inc = count + 1'b1;
      if (inc >= limit) begin
         r.done  = 1'b1;
         r.count = '0;
      end else begin
         r.done  = 1'b0;
         r.count = inc;
      end
      return r;
   endfunction

   // handshakes
   assign csr_ready  = 1'b1;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // tick logic: soft reset, posts, then one sequencer step
   always_comb begin
      phase_in        = phase_ff;
      hold_count_in   = hold_count_ff;
      bit_count_in    = bit_count_ff;
      active_plane_in = active_plane_ff;
      pend_valid_in   = pend_valid_ff;
      pend_plane_in   = pend_plane_ff;
      latch_pend_in   = latch_pend_ff;
      data_in         = data_ff;
      clk_pin_in      = clk_pin_ff;
      store_in        = store_ff;
      hs              = '0;
      bit_next        = '0;

      if (req_soft_reset) begin
         phase_in        = ophs_pkg::PH_IDLE;
         hold_count_in   = '0;
         active_plane_in = '0;
         pend_valid_in   = 1'b0;
         pend_plane_in   = '0;
         latch_pend_in   = 1'b0;
      end
      if (req_plane_valid) begin
         pend_valid_in = 1'b1;
         pend_plane_in = req_plane_index;
      end
      if (req_latch_request) begin
         latch_pend_in = 1'b1;
      end

      case (phase_in)
         ophs_pkg::PH_IDLE: begin
            if (pend_valid_in) begin
               phase_in        = ophs_pkg::PH_SET_HI;
               bit_count_in    = '0;
               active_plane_in = pend_plane_in;
               pend_valid_in   = 1'b0;
            end
         end
         ophs_pkg::PH_SET_HI, ophs_pkg::PH_WAIT_HI: begin
            if (phase_in == ophs_pkg::PH_SET_HI) begin
               data_in    = (bit_count_in == {1'b0, active_plane_in});
               clk_pin_in = 1'b1;
            end
            hs            = hold_tick(hold_count_in, hold_ticks_ff);
            hold_count_in = hs.count;
            phase_in      = hs.done ? ophs_pkg::PH_SET_LO : ophs_pkg::PH_WAIT_HI;
         end
         ophs_pkg::PH_SET_LO, ophs_pkg::PH_WAIT_LO: begin
            if (phase_in == ophs_pkg::PH_SET_LO) begin
               data_in    = 1'b0;
               clk_pin_in = 1'b0;
            end
            hs            = hold_tick(hold_count_in, hold_ticks_ff);
            hold_count_in = hs.count;
            phase_in      = ophs_pkg::PH_WAIT_LO;
            if (hs.done) begin
               bit_next     = {1'b0, bit_count_in} + 1'b1;
               bit_count_in = bit_next[BW-1:0];
               phase_in     = (bit_next >= (BW+1)'(EDGE)) ? ophs_pkg::PH_WRITTEN
                                                          : ophs_pkg::PH_SET_HI;
            end
         end
         ophs_pkg::PH_WRITTEN: begin
            if (latch_pend_in) begin
               latch_pend_in = 1'b0;
               phase_in      = ophs_pkg::PH_STO_SET_HI;
            end
         end
         ophs_pkg::PH_STO_SET_HI, ophs_pkg::PH_STO_WAIT_HI: begin
            if (phase_in == ophs_pkg::PH_STO_SET_HI) begin
               store_in = 1'b1;
            end
            hs            = hold_tick(hold_count_in, hold_ticks_ff);
            hold_count_in = hs.count;
            phase_in      = hs.done ? ophs_pkg::PH_STO_SET_LO : ophs_pkg::PH_STO_WAIT_HI;
         end
         ophs_pkg::PH_STO_SET_LO, ophs_pkg::PH_STO_WAIT_LO: begin
            if (phase_in == ophs_pkg::PH_STO_SET_LO) begin
               store_in = 1'b0;
            end
            hs            = hold_tick(hold_count_in, hold_ticks_ff);
            hold_count_in = hs.count;
            phase_in      = hs.done ? ophs_pkg::PH_IDLE : ophs_pkg::PH_STO_WAIT_LO;
         end
         default: begin
            phase_in = ophs_pkg::PH_IDLE;
         end
      endcase
   end

   // response valid: set by a request, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ophs_pkg::PH_IDLE;
         hold_count_ff   <= '0;
         bit_count_ff    <= '0;
         active_plane_ff <= '0;
         pend_valid_ff   <= 1'b0;
         pend_plane_ff   <= '0;
         latch_pend_ff   <= 1'b0;
         data_ff         <= 1'b0;
         clk_pin_ff      <= 1'b0;
         store_ff        <= 1'b0;
         hold_ticks_ff   <= ophs_pkg::HOLD_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            hold_ticks_ff <= csr_hold_ticks;
         end
         if (req_accept) begin
            phase_ff        <= phase_in;
            hold_count_ff   <= hold_count_in;
            bit_count_ff    <= bit_count_in;
            active_plane_ff <= active_plane_in;
            pend_valid_ff   <= pend_valid_in;
            pend_plane_ff   <= pend_plane_in;
            latch_pend_ff   <= latch_pend_in;
            data_ff         <= data_in;
            clk_pin_ff      <= clk_pin_in;
            store_ff        <= store_in;
         end
      end
   end

   // status part of the response
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_rfp_ff <= (phase_in == ophs_pkg::PH_IDLE);
         rsp_rtl_ff <= (phase_in == ophs_pkg::PH_WRITTEN);
      end
   end

   // pin levels are the response payload
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_out        = data_ff;
   assign rsp_clock_out       = clk_pin_ff;
   assign rsp_store_out       = store_ff;
   assign rsp_ready_for_plane = rsp_rfp_ff;
   assign rsp_ready_to_latch  = rsp_rtl_ff;

   // sequencer phase stays one-hot
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   // idle and awaiting latch are never reported together
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_ready_for_plane && rsp_ready_to_latch))
      else $error("ready_for_plane and ready_to_latch both set");

   // soft reset without a new plane leaves the sequencer idle
   a_soft_reset_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_soft_reset && !req_plane_valid)
      |=> (rsp_valid && rsp_ready_for_plane))
      else $error("soft reset did not return sequencer to idle");

   // a response waits whenever a request was just taken
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("request transaction produced no response");

endmodule

// File: tb/tb.sv
// Testbench for the one-hot plane shift and latch driver core.
module tb;

   localparam int SHIFT_LEN   = 16;
   localparam int TIMEOUT     = 1600000;
   localparam int IDLE_PCT    = 16;

   // One request transaction: a single timing tick
   typedef struct packed {
      logic                         plane_valid;
      logic [ophs_pkg::PLANE_W-1:0] plane_index;
      logic                         latch_request;
      logic                         soft_reset;
   } tick_type;

   // Pin levels and status after one tick, ready_to_latch in bit 0
   typedef struct packed {
      logic data;
      logic clk;
      logic store;
      logic idle;
      logic written;
   } pin_report_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [ophs_pkg::HOLD_W-1:0]   csr_hold_ticks;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_plane_valid;
   logic [ophs_pkg::PLANE_W-1:0]  req_plane_index;
   logic                          req_latch_request;
   logic                          req_soft_reset;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_data_out;
   logic                          rsp_clock_out;
   logic                          rsp_store_out;
   logic                          rsp_ready_for_plane;
   logic                          rsp_ready_to_latch;

   // Shadow copy of the sequencer
   ophs_pkg::phase_type           seq_phase;
   logic [ophs_pkg::HOLD_W-1:0]   hold_ticks;
   logic [ophs_pkg::HOLD_W-1:0]   hold_count;
   logic [ophs_pkg::BIT_W-1:0]    bit_count;
   logic [ophs_pkg::PLANE_W-1:0]  active_plane;
   logic [ophs_pkg::PLANE_W-1:0]  pending_plane;
   logic                          pending_valid;
   logic                          latch_pending;
   logic                          pin_data;
   logic                          pin_clock;
   logic                          pin_store;

   pin_report_type      expected_pins[$];
   string               pin_names [0:4] = '{"ready_to_latch", "ready_for_plane",
                                            "store_out", "clock_out", "data_out"};
   bit                  steady_flow;
   int                  err_count;
   int                  sent_count;
   int                  checked_count;
   int                  planes_taken;
   int                  store_pulses;

   onehot_plane_shift_latch_driver_core #(
      .EDGE(SHIFT_LEN)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_hold_ticks      (csr_hold_ticks),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_plane_valid     (req_plane_valid),
      .req_plane_index     (req_plane_index),
      .req_latch_request   (req_latch_request),
      .req_soft_reset      (req_soft_reset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_out        (rsp_data_out),
      .rsp_clock_out       (rsp_clock_out),
      .rsp_store_out       (rsp_store_out),
      .rsp_ready_for_plane (rsp_ready_for_plane),
      .rsp_ready_to_latch  (rsp_ready_to_latch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #TIMEOUT;
      $display("timeout with %0d responses outstanding", expected_pins.size());
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at response %0d: %s", checked_count, msg);
      err_count++;
   endtask

   // Hold timer: count this tick, fire once the count reaches hold_ticks
   function automatic bit hold_elapsed();
      hold_count = hold_count + 1'b1;
      if (hold_count >= hold_ticks) begin
         hold_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one tick to the shadow sequencer and queue the pin report
   task automatic predict_tick(input tick_type t);
      logic [ophs_pkg::BIT_W:0] next_bit;
      if (t.soft_reset) begin
         seq_phase     = ophs_pkg::PH_IDLE;
         hold_count    = '0;
         active_plane  = '0;
         pending_valid = 1'b0;
         pending_plane = '0;
         latch_pending = 1'b0;
      end
      if (t.plane_valid) begin
         pending_valid = 1'b1;
         pending_plane = t.plane_index;
      end
      if (t.latch_request)
         latch_pending = 1'b1;

      case (seq_phase)
         ophs_pkg::PH_IDLE: begin
            if (pending_valid) begin
               seq_phase     = ophs_pkg::PH_SET_HI;
               bit_count     = '0;
               active_plane  = pending_plane;
               pending_valid = 1'b0;
               planes_taken++;
            end
         end
         ophs_pkg::PH_SET_HI, ophs_pkg::PH_WAIT_HI: begin
            if (seq_phase == ophs_pkg::PH_SET_HI) begin
               pin_data  = (bit_count == active_plane);
               pin_clock = 1'b1;
            end
            seq_phase = ophs_pkg::PH_WAIT_HI;
            if (hold_elapsed())
               seq_phase = ophs_pkg::PH_SET_LO;
         end
         ophs_pkg::PH_SET_LO, ophs_pkg::PH_WAIT_LO: begin
            if (seq_phase == ophs_pkg::PH_SET_LO) begin
               pin_data  = 1'b0;
               pin_clock = 1'b0;
            end
            seq_phase = ophs_pkg::PH_WAIT_LO;
            if (hold_elapsed()) begin
               next_bit  = bit_count + 1'b1;
               bit_count = next_bit[ophs_pkg::BIT_W-1:0];
               seq_phase = (next_bit >= SHIFT_LEN) ? ophs_pkg::PH_WRITTEN
                                                   : ophs_pkg::PH_SET_HI;
            end
         end
         ophs_pkg::PH_WRITTEN: begin
            if (latch_pending) begin
               latch_pending = 1'b0;
               seq_phase     = ophs_pkg::PH_STO_SET_HI;
               store_pulses++;
            end
         end
         ophs_pkg::PH_STO_SET_HI, ophs_pkg::PH_STO_WAIT_HI: begin
            pin_store = 1'b1;
            seq_phase = ophs_pkg::PH_STO_WAIT_HI;
            if (hold_elapsed())
               seq_phase = ophs_pkg::PH_STO_SET_LO;
         end
         ophs_pkg::PH_STO_SET_LO, ophs_pkg::PH_STO_WAIT_LO: begin
            if (seq_phase == ophs_pkg::PH_STO_SET_LO)
               pin_store = 1'b0;
            seq_phase = ophs_pkg::PH_STO_WAIT_LO;
            if (hold_elapsed())
               seq_phase = ophs_pkg::PH_IDLE;
         end
         default: seq_phase = ophs_pkg::PH_IDLE;
      endcase

      expected_pins.push_back({pin_data, pin_clock, pin_store,
                               seq_phase == ophs_pkg::PH_IDLE,
                               seq_phase == ophs_pkg::PH_WRITTEN});
   endtask

   function automatic tick_type make_tick(input logic pv,
                                          input logic [ophs_pkg::PLANE_W-1:0] idx,
                                          input logic lr, input logic sr);
      return '{plane_valid: pv, plane_index: idx, latch_request: lr, soft_reset: sr};
   endfunction

   // Send one request transaction; unless steady_flow is set, the sender may idle first
   task automatic send_tick(input tick_type t);
      if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_plane_valid   <= t.plane_valid;
      req_plane_index   <= t.plane_index;
      req_latch_request <= t.latch_request;
      req_soft_reset    <= t.soft_reset;
      do @(posedge clock); while (req_stall);
      predict_tick(t);
      sent_count++;
      @(negedge clock);
   endtask

   // Mostly well-formed frames: post when idle, latch once shifted, some noise
   task automatic run_ticks(input int n);
      tick_type t;
      repeat (n) begin
         t.plane_index = ophs_pkg::PLANE_W'($urandom_range(15));
         if ($urandom_range(99) < 3) begin
            t.plane_valid   = 1'($urandom_range(1));
            t.latch_request = 1'($urandom_range(1));
            t.soft_reset    = 1'($urandom_range(1));
         end else begin
            t.plane_valid   = (seq_phase == ophs_pkg::PH_IDLE && !pending_valid) ?
                              ($urandom_range(99) < 70) : ($urandom_range(99) < 3);
            t.latch_request = (seq_phase == ophs_pkg::PH_WRITTEN) ?
                              ($urandom_range(99) < 60) : ($urandom_range(99) < 4);
            t.soft_reset    = ($urandom_range(99) < 1);
         end
         send_tick(t);
      end
   endtask

   // Stop sending and let every outstanding response arrive
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pins.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_hold(input logic [ophs_pkg::HOLD_W-1:0] value);
      wait_drained();
      csr_valid      <= 1'b1;
      csr_hold_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      hold_ticks = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Soft reset, early latch, post beside soft reset, post while busy
   task automatic test_directed();
      send_tick(make_tick(1'b0, 4'd0, 1'b0, 1'b1));
      send_tick(make_tick(1'b1, 4'd15, 1'b1, 1'b0));
      repeat (5) send_tick(make_tick(1'b0, 4'd0, 1'b0, 1'b0));
      // clock is high here; soft reset must leave it
      send_tick(make_tick(1'b0, 4'd0, 1'b0, 1'b1));
      send_tick(make_tick(1'b0, 4'd0, 1'b0, 1'b0));
      send_tick(make_tick(1'b1, 4'd0, 1'b0, 1'b1));
      repeat (4) send_tick(make_tick(1'b0, 4'd0, 1'b0, 1'b0));
      send_tick(make_tick(1'b1, 4'd9, 1'b0, 1'b0));
      send_tick(make_tick(1'b1, 4'd15, 1'b1, 1'b0));
      set_hold(8'd0);
      repeat (6) send_tick(make_tick(1'b0, 4'd0, 1'b0, 1'b0));
      send_tick(make_tick(1'b1, 4'd5, 1'b1, 1'b1));
      send_tick(make_tick(1'b0, 4'd0, 1'b0, 1'b0));
   endtask

   // Full frames at small holds; one pass runs with no idling on either side
   task automatic test_hold_sweep();
      logic [ophs_pkg::HOLD_W-1:0] sweep [0:4] = '{8'd0, 8'd2, 8'd1, 8'd3, 8'd0};
      for (int i = 0; i < 5; i++) begin
         set_hold(sweep[i]);
         steady_flow = (i == 2);
         run_ticks(220);
      end
      steady_flow = 1'b0;
   endtask

   // Largest hold, then lower it while a wait is under way
   task automatic test_long_hold();
      set_hold(8'd255);
      send_tick(make_tick(1'b1, 4'd1, 1'b1, 1'b0));
      run_ticks(300);
      set_hold(8'd2);
      run_ticks(120);
   endtask

   // Random small holds with a pause for a full drain in between
   task automatic test_random_holds();
      repeat (2) begin
         set_hold(ophs_pkg::HOLD_W'($urandom_range(5)));
         run_ticks(50);
         wait_drained();
         run_ticks(50);
      end
   endtask

   // Response side: random stalls
   always @(negedge clock) begin
      if (reset || steady_flow)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
   end

   // Compare each response transaction with the oldest expected report
   always @(posedge clock) begin
      pin_report_type seen;
      pin_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_data_out, rsp_clock_out, rsp_store_out,
                 rsp_ready_for_plane, rsp_ready_to_latch};
         if (expected_pins.size() == 0) begin
            report_mismatch($sformatf("unexpected response %b", seen));
         end else begin
            want = expected_pins.pop_front();
            for (int i = 0; i < 5; i++)
               if (seen[i] !== want[i])
                  report_mismatch($sformatf("%s got %b want %b",
                                            pin_names[i], seen[i], want[i]));
         end
         checked_count++;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_hold_ticks    = '0;
      req_valid         = 1'b0;
      req_plane_valid   = 1'b0;
      req_plane_index   = '0;
      req_latch_request = 1'b0;
      req_soft_reset    = 1'b0;
      rsp_stall         = 1'b0;
      steady_flow       = 1'b0;
      err_count         = 0;
      sent_count        = 0;
      checked_count     = 0;
      planes_taken      = 0;
      store_pulses      = 0;
      seq_phase         = ophs_pkg::PH_IDLE;
      hold_ticks        = ophs_pkg::HOLD_RESET;
      hold_count        = '0;
      bit_count         = '0;
      active_plane      = '0;
      pending_plane     = '0;
      pending_valid     = 1'b0;
      latch_pending     = 1'b0;
      pin_data          = 1'b0;
      pin_clock         = 1'b0;
      pin_store         = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_hold_sweep();
      test_long_hold();
      test_random_holds();

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d ticks, checked %0d responses, %0d planes shifted, %0d store pulses",
               sent_count, checked_count, planes_taken, store_pulses);
      $display("Holds 0 to 3, 255 and a cut mid-wait, with soft resets and early latches");
      if (err_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/ophs_pkg.sv
rtl/onehot_plane_shift_latch_driver_core.sv
tb/tb.sv
